// ===== hw/rtl/source_text_lexer_unit_assert.svh =====
// Assertion macros for the source text lexer.
`ifndef SOURCE_TEXT_LEXER_UNIT_ASSERT_SVH
`define SOURCE_TEXT_LEXER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define SLU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("slu assertion failed");

// Next-cycle implication, disabled in reset.
`define SLU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("slu assertion failed");

`endif

// ===== hw/rtl/slu_pkg.sv =====
package slu_pkg;

	localparam int POS_BITS  = 16;
	localparam int LINE_BITS = 16;
	localparam int LEN_BITS  = POS_BITS + 1;
	localparam int FIELD_W   = 16;
	localparam int KIND_W    = 5;
	localparam int MAX_TOK   = 3;
	localparam int TOK_CNT_W = $clog2(MAX_TOK + 1);
	localparam int Q_DEPTH   = 4;
	localparam int Q_IDX_W   = $clog2(Q_DEPTH);
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

	typedef enum logic [KIND_W-1:0] {
		K_WORD, K_STRING, K_COMMA, K_NEWLINE, K_TAB,
		K_LPAREN, K_RPAREN, K_LBRACK, K_RBRACK, K_LBRACE, K_RBRACE,
		K_ARROW, K_PLUS, K_MINUS, K_STAR, K_SLASH,
		K_LE, K_LT, K_GE, K_GT, K_EQ, K_NE,
		K_END, K_BAD_CHAR, K_OPEN_STRING
	} kind_t;

	typedef enum logic [2:0] {
		MODE_IDLE, MODE_WORD, MODE_STRING, MODE_COMMENT, MODE_HALT, MODE_OP
	} mode_t;

	typedef enum logic [1:0] {
		OP_LT, OP_GT, OP_BANG, OP_SLASH
	} op_t;

	typedef struct packed {
		kind_t                kind;
		logic [LINE_BITS-1:0] line;
		logic [POS_BITS-1:0]  start;
		logic [LEN_BITS-1:0]  len;
	} tok_t;

	typedef struct packed {
		logic [TOK_CNT_W-1:0] cnt;
		tok_t [MAX_TOK-1:0]   tok;
	} bundle_t;

	typedef struct packed {
		logic               empty;
		logic               full;
	} q_stat_t;

endpackage

// ===== hw/rtl/slu_byte_if.sv =====
interface slu_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/slu_token_if.sv =====
interface slu_token_if;
	import slu_pkg::*;

	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  token_kind;
	logic [FIELD_W-1:0] token_line;
	logic [FIELD_W-1:0] token_start;
	logic [FIELD_W-1:0] token_length;
	logic               last_result;

	modport source (output valid, output token_kind, output token_line, output token_start,
		output token_length, output last_result, input ready);
	modport sink   (input valid, input token_kind, input token_line, input token_start,
		input token_length, input last_result, output ready);
endinterface

// ===== hw/rtl/slu_front.sv =====
module slu_front (
	input  logic             clk,
	input  logic             arst_n,
	slu_byte_if.sink         text,
	input  slu_pkg::q_stat_t stat,
	output logic             push,
	output slu_pkg::bundle_t push_data
);
	import slu_pkg::*;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
	localparam logic [POS_BITS-1:0]  POS_MAX  = '1;

	mode_t                mode_q, mode_d;
	op_t                  op_q, op_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [POS_BITS-1:0]  pos_q;
	logic [POS_BITS-1:0]  begin_q, begin_d;
	logic                 ls_q, ls_d;
	logic                 bs_q, bs_d;
	logic                 accept;
	logic [TOK_CNT_W-1:0] n_tok;
	tok_t [MAX_TOK-1:0]   toks;

	function automatic logic is_word(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h5F});
	endfunction

	function automatic logic is_single(input logic [7:0] c);
		return (c inside {CH_COMMA, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
			CH_RBRACE, CH_PLUS, CH_MINUS, CH_STAR, CH_EQ});
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_COMMA:  k = K_COMMA;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACK: k = K_LBRACK;
			CH_RBRACK: k = K_RBRACK;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_PLUS:   k = K_PLUS;
			CH_MINUS:  k = K_MINUS;
			CH_STAR:   k = K_STAR;
			CH_EQ:     k = K_EQ;
			default:   k = K_BAD_CHAR;
		endcase
		return k;
	endfunction

	function automatic kind_t held_kind(input op_t op);
		kind_t k;
		case (op)
			OP_LT:   k = K_LT;
			OP_GT:   k = K_GT;
			default: k = K_SLASH;
		endcase
		return k;
	endfunction

	function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
		return (l == LINE_MAX) ? l : l + 1'b1;
	endfunction

	assign text.ready = !stat.full;
	assign accept     = text.valid && !stat.full;

	always_comb begin
		logic [7:0]          c;
		logic [POS_BITS-1:0] pos;
		logic                do_fresh;
		logic                hit;
		kind_t               k;
		c        = text.in_byte;
		pos      = pos_q;
		mode_d   = mode_q;
		op_d     = op_q;
		line_d   = line_q;
		begin_d  = begin_q;
		ls_d     = ls_q;
		bs_d     = bs_q;
		n_tok    = '0;
		toks     = '0;
		do_fresh = 1'b0;
		hit      = 1'b0;
		k        = K_WORD;

		case (mode_q)
			MODE_HALT: begin
			end
			MODE_COMMENT: begin
				if (c == CH_NL) begin
					line_d = line_inc(line_d);
					ls_d   = 1'b1;
					mode_d = MODE_IDLE;
				end
			end
			MODE_STRING: begin
				if (c == CH_QUOTE && !bs_q) begin
					toks[n_tok] = '{K_STRING, line_d, begin_d,
						LEN_BITS'(pos) - LEN_BITS'(begin_d) + 1'b1};
					n_tok  = n_tok + 1'b1;
					mode_d = MODE_IDLE;
					ls_d   = 1'b0;
				end else begin
					bs_d = (c == CH_BSLASH);
				end
			end
			MODE_OP: begin
				if (op_q == OP_LT && c == CH_MINUS) begin
					k = K_ARROW; hit = 1'b1;
				end else if (op_q == OP_LT && c == CH_EQ) begin
					k = K_LE; hit = 1'b1;
				end else if (op_q == OP_GT && c == CH_EQ) begin
					k = K_GE; hit = 1'b1;
				end else if (op_q == OP_BANG && c == CH_EQ) begin
					k = K_NE; hit = 1'b1;
				end
				if (hit) begin
					toks[n_tok] = '{k, line_d, begin_d, LEN_BITS'(2)};
					n_tok  = n_tok + 1'b1;
					mode_d = MODE_IDLE;
					ls_d   = 1'b0;
				end else if (op_q == OP_SLASH && c == CH_SLASH) begin
					toks[n_tok] = '{K_NEWLINE, line_d, begin_d, LEN_BITS'(1)};
					n_tok  = n_tok + 1'b1;
					mode_d = MODE_COMMENT;
				end else if (op_q == OP_BANG) begin
					toks[n_tok] = '{K_BAD_CHAR, line_d, begin_d, LEN_BITS'(1)};
					n_tok  = n_tok + 1'b1;
					mode_d = MODE_HALT;
				end else begin
					toks[n_tok] = '{held_kind(op_q), line_d, begin_d, LEN_BITS'(1)};
					n_tok    = n_tok + 1'b1;
					mode_d   = MODE_IDLE;
					ls_d     = 1'b0;
					do_fresh = 1'b1;
				end
			end
			default: begin
				if (mode_q != MODE_WORD) mode_d = MODE_IDLE;
				do_fresh = 1'b1;
			end
		endcase

		if (do_fresh) begin
			if (is_word(c)) begin
				if (mode_d != MODE_WORD) begin
					mode_d  = MODE_WORD;
					begin_d = pos;
				end
				ls_d = 1'b0;
			end else if (!is_single(c) && !(c inside {CH_SPACE, CH_TAB, CH_NL, CH_QUOTE,
				CH_LT, CH_GT, CH_BANG, CH_SLASH})) begin
				// bad char drops any word in progress
				toks[n_tok] = '{K_BAD_CHAR, line_d, pos, LEN_BITS'(1)};
				n_tok  = n_tok + 1'b1;
				mode_d = MODE_HALT;
			end else begin
				if (mode_d == MODE_WORD) begin
					toks[n_tok] = '{K_WORD, line_d, begin_d,
						LEN_BITS'(pos) - LEN_BITS'(begin_d)};
					n_tok = n_tok + 1'b1;
				end
				mode_d = MODE_IDLE;
				case (c)
					CH_SPACE: begin
					end
					CH_TAB: begin
						if (ls_d) begin
							toks[n_tok] = '{K_TAB, line_d, pos, LEN_BITS'(1)};
							n_tok = n_tok + 1'b1;
						end
					end
					CH_NL: begin
						toks[n_tok] = '{K_NEWLINE, line_d, pos, LEN_BITS'(1)};
						n_tok  = n_tok + 1'b1;
						line_d = line_inc(line_d);
						ls_d   = 1'b1;
					end
					CH_QUOTE: begin
						mode_d  = MODE_STRING;
						begin_d = pos;
						bs_d    = 1'b0;
					end
					CH_LT, CH_GT, CH_BANG, CH_SLASH: begin
						mode_d  = MODE_OP;
						begin_d = pos;
						op_d    = (c == CH_LT) ? OP_LT : (c == CH_GT) ? OP_GT :
							(c == CH_BANG) ? OP_BANG : OP_SLASH;
					end
					default: begin
						toks[n_tok] = '{single_kind(c), line_d, pos, LEN_BITS'(1)};
						n_tok = n_tok + 1'b1;
						ls_d  = 1'b0;
					end
				endcase
			end
		end

		if (text.end_of_input) begin
			case (mode_d)
				MODE_WORD: begin
					toks[n_tok] = '{K_WORD, line_d, begin_d,
						LEN_BITS'(pos) - LEN_BITS'(begin_d) + 1'b1};
					n_tok = n_tok + 1'b1;
				end
				MODE_OP: begin
					toks[n_tok] = '{(op_d == OP_BANG) ? K_BAD_CHAR : held_kind(op_d),
						line_d, begin_d, LEN_BITS'(1)};
					n_tok = n_tok + 1'b1;
				end
				MODE_STRING: begin
					toks[n_tok] = '{K_OPEN_STRING, line_d, begin_d, LEN_BITS'(1)};
					n_tok = n_tok + 1'b1;
				end
				default: begin
				end
			endcase
			toks[n_tok] = '{K_END, line_d, pos, LEN_BITS'(0)};
			n_tok = n_tok + 1'b1;
		end
	end

	assign push          = accept && (n_tok != '0);
	assign push_data.cnt = n_tok;
	assign push_data.tok = toks;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			op_q    <= OP_LT;
			line_q  <= LINE_BITS'(1);
			pos_q   <= '0;
			begin_q <= '0;
			ls_q    <= 1'b1;
			bs_q    <= 1'b0;
		end else if (accept) begin
			if (text.end_of_input) begin
				mode_q  <= MODE_IDLE;
				op_q    <= OP_LT;
				line_q  <= LINE_BITS'(1);
				pos_q   <= '0;
				begin_q <= '0;
				ls_q    <= 1'b1;
				bs_q    <= 1'b0;
			end else begin
				mode_q  <= mode_d;
				op_q    <= op_d;
				line_q  <= line_d;
				pos_q   <= (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
				begin_q <= begin_d;
				ls_q    <= ls_d;
				bs_q    <= bs_d;
			end
		end
	end

endmodule

// ===== hw/rtl/slu_queue.sv =====
module slu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slu_pkg::bundle_t  push_data,
	input  logic              pop,
	output slu_pkg::bundle_t  head,
	output slu_pkg::q_stat_t  stat
);
	import slu_pkg::*;

	bundle_t              mem_q [Q_DEPTH];
	logic [Q_IDX_W-1:0]   wr_q;
	logic [Q_IDX_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	assign head       = mem_q[rd_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == Q_CNT_W'(Q_DEPTH));

endmodule

// ===== hw/rtl/slu_back.sv =====
module slu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  slu_pkg::bundle_t head,
	input  slu_pkg::q_stat_t stat,
	output logic             pop,
	slu_token_if.source      tokens
);
	import slu_pkg::*;

	bundle_t              b_q;
	logic [TOK_CNT_W-1:0] idx_q;
	logic                 valid_q;
	logic                 final_tok;
	tok_t                 cur;

	assign final_tok = (idx_q == b_q.cnt - 1'b1);
	assign pop       = !stat.empty && (!valid_q || (tokens.ready && final_tok));
	assign cur       = b_q.tok[idx_q];

	always_ff @(posedge clk) begin
		if (pop) b_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (pop) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && tokens.ready) begin
			if (final_tok) valid_q <= 1'b0;
			else           idx_q   <= idx_q + 1'b1;
		end
	end

	assign tokens.valid        = valid_q;
	assign tokens.token_kind   = cur.kind;
	assign tokens.token_line   = FIELD_W'(cur.line);
	assign tokens.token_start  = FIELD_W'(cur.start);
	assign tokens.token_length = FIELD_W'(cur.len);
	assign tokens.last_result  = final_tok;

endmodule

// ===== hw/rtl/source_text_lexer_unit.sv =====
// A byte's first token word is written into the bundle queue, then loaded into the output
// register and shown; a byte yielding no token gives no word.
// Throughput: one byte per cycle while the queue is not full; words drain at one per cycle
// through a 4-bundle queue while tokens.ready is high, one word per token.
// Reset (arst_n low, async): lexer state to line 1, offset 0, queue and output emptied.
module source_text_lexer_unit (
	input  logic         clk,
	input  logic         arst_n,
	slu_byte_if.sink     text,
	slu_token_if.source  tokens
);
	import slu_pkg::*;

	logic    push;
	logic    pop;
	bundle_t push_data;
	bundle_t head;
	q_stat_t stat;

	slu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	slu_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	slu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.stat   (stat),
		.pop    (pop),
		.tokens (tokens)
	);

`include "source_text_lexer_unit_assert.svh"

	`SLU_ASSERT_NOW(a_full_stalls, clk, arst_n, stat.full, !text.ready)
	`SLU_ASSERT_NOW(a_push_nonempty, clk, arst_n, push, push_data.cnt != '0)
	`SLU_ASSERT_NOW(a_end_is_last, clk, arst_n,
		tokens.valid && tokens.token_kind == K_END, tokens.last_result)
	`SLU_ASSERT_NEXT(a_end_queued, clk, arst_n,
		text.valid && text.ready && text.end_of_input, !stat.empty)

endmodule
